// File: rtl/emrc_pkg.sv
package emrc_pkg;

  localparam int unsigned NUM_COEF = 8;

  localparam logic [2:0] REG_COEF_CURRENT_A = 3'd0;
  localparam logic [2:0] REG_COEF_CURRENT_B = 3'd1;
  localparam logic [2:0] REG_COEF_VOLTAGE   = 3'd2;
  localparam logic [2:0] REG_COEF_POWER_A   = 3'd3;
  localparam logic [2:0] REG_COEF_POWER_B   = 3'd4;
  localparam logic [2:0] REG_COEF_APPARENT  = 3'd5;
  localparam logic [2:0] REG_COEF_ENERGY_A  = 3'd6;
  localparam logic [2:0] REG_COEF_ENERGY_B  = 3'd7;

  localparam logic [3:0] MS_VOLT  = 4'd0;
  localparam logic [3:0] MS_AMP_A = 4'd1;
  localparam logic [3:0] MS_AMP_B = 4'd2;
  localparam logic [3:0] MS_PWR_A = 4'd3;
  localparam logic [3:0] MS_PWR_B = 4'd4;
  localparam logic [3:0] MS_EN_A  = 4'd5;
  localparam logic [3:0] MS_EN_B  = 4'd6;
  localparam logic [3:0] MS_PF    = 4'd7;
  localparam logic [3:0] MS_PHASE = 4'd8;

  localparam logic [28:0] FREQ_NUM    = 29'd357954500;
  localparam logic [25:0] PHASE_RECIP = 26'd42949673;
  localparam logic [25:0] FREQ_SLOPE  = 26'd5500;
  localparam logic [15:0] SLOPE_LOW   = 16'd805;
  localparam logic [15:0] SLOPE_HIGH  = 16'd965;
  localparam logic [15:0] MILLI       = 16'd1000;
  localparam logic [23:0] PF_DIV      = 24'd8388607;
  localparam logic [23:0] PF_NEG      = 24'h800000;
  localparam logic [31:0] PWR_NEG     = 32'h80000000;
  localparam logic [47:0] VOLT_LIM    = 48'd209715200000;
  localparam logic [47:0] AMP_LIM     = 48'd1258291200000;
  localparam logic [47:0] WATT_LIM    = 48'd161061273600000;
  localparam logic [25:0] PF_MIN_MW   = 26'd300;
  localparam logic [25:0] PH_MIN_MW   = 26'd500;

  typedef struct packed {
    logic       load;
    logic       start_f;
    logic       cap_f;
    logic       mul_en;
    logic [3:0] mul_sel;
    logic       cap_p;
    logic       finish;
  } emrc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_stall;
  } emrc_sts_t;

endpackage

// File: rtl/energy_meter_result_converter_core.sv
// energy meter result converter
// input channel (in_valid/in_ready): one frame of raw readings plus the
// factory checksum word; the frame is captured when in_valid and in_ready
// are both high. config channel (cfg_valid/cfg_ready, always ready): writes
// coefficient cfg_index with cfg_data; write only while no item is in flight.
// result channel (out_valid/out_ready): one converted item per input item,
// held flags a bad frame replaced by the last good one.
// steps: start the period divide, the divide itself, the shared 32x16
// multiplier steps, the phase scaling, then finish. one item at a time: a
// new item is accepted only once the last one has finished, and the
// restoring period divider takes most of the time per item.
// the result sits in an output register; the next item is accepted while
// it waits, and a stalled receiver holds the finished item in the final
// step until the output register frees.
// reset (rst_n low, synchronous): coefficients zero, no saved frame,
// out_valid low.
module energy_meter_result_converter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_raw_period,
  input  logic [23:0] in_raw_volt,
  input  logic [23:0] in_raw_amp_a,
  input  logic [23:0] in_raw_amp_b,
  input  logic [31:0] in_raw_watt_a,
  input  logic [31:0] in_raw_watt_b,
  input  logic [23:0] in_raw_energy_a,
  input  logic [23:0] in_raw_energy_b,
  input  logic [23:0] in_raw_pfactor,
  input  logic [15:0] in_raw_phase,
  input  logic [15:0] in_factory_checksum,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_cal_match,
  output logic [25:0] out_freq_centihz,
  output logic [16:0] out_volt_centiv,
  output logic [15:0] out_amp_a_ma,
  output logic [15:0] out_amp_b_ma,
  output logic [25:0] out_watt_a_mw,
  output logic [25:0] out_watt_b_mw,
  output logic [20:0] out_energy_a_wh,
  output logic [20:0] out_energy_b_wh,
  output logic [9:0]  out_pfactor_milli,
  output logic [19:0] out_phase_centideg,
  output logic        out_held
);

  emrc_pkg::emrc_cmd_t cmd;
  emrc_pkg::emrc_sts_t sts;

  emrc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  emrc_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_raw_period       (in_raw_period),
    .in_raw_volt         (in_raw_volt),
    .in_raw_amp_a        (in_raw_amp_a),
    .in_raw_amp_b        (in_raw_amp_b),
    .in_raw_watt_a       (in_raw_watt_a),
    .in_raw_watt_b       (in_raw_watt_b),
    .in_raw_energy_a     (in_raw_energy_a),
    .in_raw_energy_b     (in_raw_energy_b),
    .in_raw_pfactor      (in_raw_pfactor),
    .in_raw_phase        (in_raw_phase),
    .in_factory_checksum (in_factory_checksum),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_cal_match       (out_cal_match),
    .out_freq_centihz    (out_freq_centihz),
    .out_volt_centiv     (out_volt_centiv),
    .out_amp_a_ma        (out_amp_a_ma),
    .out_amp_b_ma        (out_amp_b_ma),
    .out_watt_a_mw       (out_watt_a_mw),
    .out_watt_b_mw       (out_watt_b_mw),
    .out_energy_a_wh     (out_energy_a_wh),
    .out_energy_b_wh     (out_energy_b_wh),
    .out_pfactor_milli   (out_pfactor_milli),
    .out_phase_centideg  (out_phase_centideg),
    .out_held            (out_held)
  );

endmodule

// File: rtl/emrc_div.sv
module emrc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [28:0] dividend,
  input  logic [18:0] divisor,
  output logic        done,
  output logic [28:0] quotient
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [18:0] rem_r, rem_nxt;
  logic [28:0] quo_r, quo_nxt;
  logic [18:0] div_r, div_nxt;
  logic [19:0] shifted;
  logic        ge;

  always_comb begin
    shifted  = {rem_r, quo_r[28]};
    ge       = shifted >= {1'b0, div_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd28;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? 19'(shifted - {1'b0, div_r}) : shifted[18:0];
      quo_nxt = {quo_r[27:0], ge};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: rtl/emrc_dp.sv
module emrc_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [15:0]         in_raw_period,
  input  logic [23:0]         in_raw_volt,
  input  logic [23:0]         in_raw_amp_a,
  input  logic [23:0]         in_raw_amp_b,
  input  logic [31:0]         in_raw_watt_a,
  input  logic [31:0]         in_raw_watt_b,
  input  logic [23:0]         in_raw_energy_a,
  input  logic [23:0]         in_raw_energy_b,
  input  logic [23:0]         in_raw_pfactor,
  input  logic [15:0]         in_raw_phase,
  input  logic [15:0]         in_factory_checksum,
  input  emrc_pkg::emrc_cmd_t cmd,
  output emrc_pkg::emrc_sts_t sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_cal_match,
  output logic [25:0]         out_freq_centihz,
  output logic [16:0]         out_volt_centiv,
  output logic [15:0]         out_amp_a_ma,
  output logic [15:0]         out_amp_b_ma,
  output logic [25:0]         out_watt_a_mw,
  output logic [25:0]         out_watt_b_mw,
  output logic [20:0]         out_energy_a_wh,
  output logic [20:0]         out_energy_b_wh,
  output logic [9:0]          out_pfactor_milli,
  output logic [19:0]         out_phase_centideg,
  output logic                out_held
);

  logic [15:0] coef_r [emrc_pkg::NUM_COEF];

  logic [15:0] period_r;
  logic [23:0] volt_raw_r, ia_raw_r, ib_raw_r, ea_raw_r, eb_raw_r, pf_raw_r;
  logic [31:0] wa_raw_r, wb_raw_r;
  logic [15:0] ph_raw_r, chk_r;

  logic [47:0] vprod_r, iaprod_r, ibprod_r, paprod_r, pbprod_r, eaprod_r, ebprod_r;
  logic [33:0] pfx_r;
  logic [25:0] phmul_r;
  logic [25:0] freq_r;
  logic [19:0] phq_r;

  logic        sv_calib_r, have_saved_r;
  logic [25:0] sv_freq_r, sv_watt_a_r, sv_watt_b_r;
  logic [16:0] sv_volt_r;
  logic [15:0] sv_amp_a_r, sv_amp_b_r;
  logic [20:0] sv_en_a_r, sv_en_b_r;
  logic [9:0]  sv_pf_r;
  logic [19:0] sv_ph_r;

  logic        o_valid_r, o_valid_nxt;
  logic        o_calib_r, o_held_r;
  logic [25:0] o_freq_r, o_watt_a_r, o_watt_b_r;
  logic [16:0] o_volt_r;
  logic [15:0] o_amp_a_r, o_amp_b_r;
  logic [20:0] o_en_a_r, o_en_b_r;
  logic [9:0]  o_pf_r;
  logic [19:0] o_ph_r;

  logic        div_start, div_done;
  logic [28:0] div_dvd, div_quo;
  logic [18:0] div_dvs;

  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic [47:0] mul_p;
  logic [23:0] pf_q;
  logic [51:0] ph_prod;

  logic [15:0] csum;
  logic        calib;
  logic [57:0] wa_t, wb_t;
  logic [49:0] ea_t, eb_t;
  logic [25:0] watt_a, watt_b;
  logic [20:0] en_a, en_b;
  logic [10:0] pf_hi;
  logic [23:0] pf_rem;
  logic [9:0]  pf_val, pf_g;
  logic [19:0] ph_g;
  logic        bad;

  function automatic logic [23:0] rms_mask(input logic [23:0] raw);
    rms_mask = raw[23] ? 24'd0 : raw;
  endfunction

  function automatic logic [31:0] pwr_mag(input logic [31:0] raw);
    pwr_mag = (raw > emrc_pkg::PWR_NEG) ? ~raw : raw;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < emrc_pkg::NUM_COEF; k++) begin
        coef_r[k] <= '0;
      end
    end else if (cfg_valid) begin
      coef_r[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      period_r   <= in_raw_period;
      volt_raw_r <= in_raw_volt;
      ia_raw_r   <= in_raw_amp_a;
      ib_raw_r   <= in_raw_amp_b;
      wa_raw_r   <= in_raw_watt_a;
      wb_raw_r   <= in_raw_watt_b;
      ea_raw_r   <= in_raw_energy_a;
      eb_raw_r   <= in_raw_energy_b;
      pf_raw_r   <= in_raw_pfactor;
      ph_raw_r   <= in_raw_phase;
      chk_r      <= in_factory_checksum;
    end
  end

  assign div_start = cmd.start_f;
  assign div_dvd   = emrc_pkg::FREQ_NUM;
  assign div_dvs   = {period_r, 3'b0};

  emrc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  // divide by 100 as reciprocal multiply, exact for 26-bit dividends
  assign ph_prod = 52'(phmul_r) * 52'(emrc_pkg::PHASE_RECIP);

  always_ff @(posedge clk) begin
    if (cmd.cap_f) begin
      freq_r <= (period_r == 16'd0) ? 26'd0 : div_quo[25:0];
    end
    if (cmd.cap_p) begin
      phq_r <= ph_prod[51:32];
    end
  end

  assign pf_q = (pf_raw_r > emrc_pkg::PF_NEG) ? 24'(25'h1000000 - {1'b0, pf_raw_r})
                                              : pf_raw_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      emrc_pkg::MS_VOLT: begin
        mul_a = {8'd0, rms_mask(volt_raw_r)};
        mul_b = coef_r[emrc_pkg::REG_COEF_VOLTAGE];
      end
      emrc_pkg::MS_AMP_A: begin
        mul_a = {8'd0, rms_mask(ia_raw_r)};
        mul_b = coef_r[emrc_pkg::REG_COEF_CURRENT_A];
      end
      emrc_pkg::MS_AMP_B: begin
        mul_a = {8'd0, rms_mask(ib_raw_r)};
        mul_b = coef_r[emrc_pkg::REG_COEF_CURRENT_B];
      end
      emrc_pkg::MS_PWR_A: begin
        mul_a = pwr_mag(wa_raw_r);
        mul_b = coef_r[emrc_pkg::REG_COEF_POWER_A];
      end
      emrc_pkg::MS_PWR_B: begin
        mul_a = pwr_mag(wb_raw_r);
        mul_b = coef_r[emrc_pkg::REG_COEF_POWER_B];
      end
      emrc_pkg::MS_EN_A: begin
        mul_a = {8'd0, ea_raw_r};
        mul_b = coef_r[emrc_pkg::REG_COEF_ENERGY_A];
      end
      emrc_pkg::MS_EN_B: begin
        mul_a = {8'd0, eb_raw_r};
        mul_b = coef_r[emrc_pkg::REG_COEF_ENERGY_B];
      end
      emrc_pkg::MS_PF: begin
        mul_a = {8'd0, pf_q};
        mul_b = emrc_pkg::MILLI;
      end
      emrc_pkg::MS_PHASE: begin
        mul_a = {16'd0, ph_raw_r};
        mul_b = (freq_r < emrc_pkg::FREQ_SLOPE) ? emrc_pkg::SLOPE_LOW
                                                : emrc_pkg::SLOPE_HIGH;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = 48'(mul_a) * 48'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        emrc_pkg::MS_VOLT:  vprod_r  <= mul_p;
        emrc_pkg::MS_AMP_A: iaprod_r <= mul_p;
        emrc_pkg::MS_AMP_B: ibprod_r <= mul_p;
        emrc_pkg::MS_PWR_A: paprod_r <= mul_p;
        emrc_pkg::MS_PWR_B: pbprod_r <= mul_p;
        emrc_pkg::MS_EN_A:  eaprod_r <= mul_p;
        emrc_pkg::MS_EN_B:  ebprod_r <= mul_p;
        emrc_pkg::MS_PF:    pfx_r    <= mul_p[33:0];
        emrc_pkg::MS_PHASE: phmul_r  <= mul_p[25:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    csum = 16'hFFFF;
    for (int k = 0; k < emrc_pkg::NUM_COEF; k++) begin
      csum = csum + coef_r[k];
    end
    calib = (~csum == chk_r) && (chk_r != 16'd0);
  end

  // times 1000 as 1024 - 16 - 8
  assign wa_t   = {paprod_r, 10'd0} - {6'd0, paprod_r, 4'd0} - {7'd0, paprod_r, 3'd0};
  assign wb_t   = {pbprod_r, 10'd0} - {6'd0, pbprod_r, 4'd0} - {7'd0, pbprod_r, 3'd0};
  assign ea_t   = {eaprod_r[39:0], 10'd0} - {6'd0, eaprod_r[39:0], 4'd0}
                - {7'd0, eaprod_r[39:0], 3'd0};
  assign eb_t   = {ebprod_r[39:0], 10'd0} - {6'd0, ebprod_r[39:0], 4'd0}
                - {7'd0, ebprod_r[39:0], 3'd0};
  assign watt_a = wa_t[56:31];
  assign watt_b = wb_t[56:31];
  assign en_a   = ea_t[49:29];
  assign en_b   = eb_t[49:29];

  // divide by 2^23 - 1: quotient estimate plus one correction
  assign pf_hi  = pfx_r[33:23];
  assign pf_rem = {1'b0, pfx_r[22:0]} + {13'd0, pf_hi};
  assign pf_val = (pf_rem >= emrc_pkg::PF_DIV) ? 10'(pf_hi + 11'd1) : pf_hi[9:0];
  assign pf_g   = (watt_a < emrc_pkg::PF_MIN_MW) ? 10'd0 : pf_val;
  assign ph_g   = (watt_a < emrc_pkg::PH_MIN_MW) ? 20'd0 : phq_r;

  assign bad = (vprod_r > emrc_pkg::VOLT_LIM) || (iaprod_r > emrc_pkg::AMP_LIM)
            || (paprod_r > emrc_pkg::WATT_LIM);

  always_comb begin
    o_valid_nxt = o_valid_r;
    if (cmd.finish) begin
      o_valid_nxt = 1'b1;
    end else if (out_ready) begin
      o_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r    <= 1'b0;
      have_saved_r <= 1'b0;
      sv_calib_r   <= 1'b0;
      sv_freq_r    <= '0;
      sv_volt_r    <= '0;
      sv_amp_a_r   <= '0;
      sv_amp_b_r   <= '0;
      sv_watt_a_r  <= '0;
      sv_watt_b_r  <= '0;
      sv_en_a_r    <= '0;
      sv_en_b_r    <= '0;
      sv_pf_r      <= '0;
      sv_ph_r      <= '0;
    end else begin
      o_valid_r <= o_valid_nxt;
      if (cmd.finish && !(bad && have_saved_r)) begin
        have_saved_r <= 1'b1;
        sv_calib_r   <= calib;
        sv_freq_r    <= freq_r;
        sv_volt_r    <= vprod_r[38:22];
        sv_amp_a_r   <= iaprod_r[38:23];
        sv_amp_b_r   <= ibprod_r[38:23];
        sv_watt_a_r  <= watt_a;
        sv_watt_b_r  <= watt_b;
        sv_en_a_r    <= en_a;
        sv_en_b_r    <= en_b;
        sv_pf_r      <= pf_g;
        sv_ph_r      <= ph_g;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (bad && have_saved_r) begin
        o_calib_r  <= sv_calib_r;
        o_freq_r   <= sv_freq_r;
        o_volt_r   <= sv_volt_r;
        o_amp_a_r  <= sv_amp_a_r;
        o_amp_b_r  <= sv_amp_b_r;
        o_watt_a_r <= sv_watt_a_r;
        o_watt_b_r <= sv_watt_b_r;
        o_en_a_r   <= sv_en_a_r;
        o_en_b_r   <= sv_en_b_r;
        o_pf_r     <= sv_pf_r;
        o_ph_r     <= sv_ph_r;
        o_held_r   <= 1'b1;
      end else begin
        o_calib_r  <= calib;
        o_freq_r   <= freq_r;
        o_volt_r   <= vprod_r[38:22];
        o_amp_a_r  <= iaprod_r[38:23];
        o_amp_b_r  <= ibprod_r[38:23];
        o_watt_a_r <= watt_a;
        o_watt_b_r <= watt_b;
        o_en_a_r   <= en_a;
        o_en_b_r   <= en_b;
        o_pf_r     <= pf_g;
        o_ph_r     <= ph_g;
        o_held_r   <= 1'b0;
      end
    end
  end

  assign sts.div_done  = div_done;
  assign sts.out_stall = o_valid_r && !out_ready;

  assign out_valid          = o_valid_r;
  assign out_cal_match      = o_calib_r;
  assign out_freq_centihz   = o_freq_r;
  assign out_volt_centiv    = o_volt_r;
  assign out_amp_a_ma       = o_amp_a_r;
  assign out_amp_b_ma       = o_amp_b_r;
  assign out_watt_a_mw      = o_watt_a_r;
  assign out_watt_b_mw      = o_watt_b_r;
  assign out_energy_a_wh    = o_en_a_r;
  assign out_energy_b_wh    = o_en_b_r;
  assign out_pfactor_milli  = o_pf_r;
  assign out_phase_centideg = o_ph_r;
  assign out_held           = o_held_r;

`ifndef NO_ASSERTIONS
  a_held_needs_saved: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid_r && o_held_r |-> have_saved_r)
    else $error("held item without a saved frame");

  a_pf_range: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid_r |-> o_pf_r <= 10'd1000)
    else $error("power factor above one");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(o_valid_r && !out_ready))
    else $error("result overwritten while stalled");
`endif

endmodule

// File: rtl/emrc_ctrl.sv
module emrc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  emrc_pkg::emrc_sts_t sts,
  output emrc_pkg::emrc_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SF   = 3'd1;
  localparam logic [2:0] S_WF   = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_PH   = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [3:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SF;
        end
      end
      S_SF: begin
        cmd.start_f = 1'b1;
        state_nxt   = S_WF;
      end
      S_WF: begin
        if (sts.div_done) begin
          cmd.cap_f = 1'b1;
          step_nxt  = emrc_pkg::MS_VOLT;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = step_r;
        step_nxt    = step_r + 4'd1;
        if (step_r == emrc_pkg::MS_PHASE) begin
          state_nxt = S_PH;
        end
      end
      S_PH: begin
        cmd.cap_p = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_stall) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule
